/* rtl/core/cell_averaging_cfar_detector_assert.svh */
// Assertion macros used by the detector's checker file.
`ifndef CELL_AVERAGING_CFAR_DETECTOR_ASSERT_SVH
`define CELL_AVERAGING_CFAR_DETECTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CACFAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CACFAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cacfar_pkg.sv */
// Shared constants and types of the cell-averaging CFAR detector.
package cacfar_pkg;

  localparam int GAIN_W     = 16;
  localparam int MAXDET_W   = 6;
  localparam int BIN_W      = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd768;
  localparam logic [MAXDET_W-1:0] MAXDET_RST = 6'd10;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_Q8 = 1'b0,
    CFG_MAX_DET = 1'b1
  } cfg_idx_e;

  // Per-beat control that travels with the window snapshot
  typedef struct packed {
    logic             tested;
    logic             frame_end;
    logic [BIN_W-1:0] cut_bin;
  } win_ctrl_t;

  // Result beat payload
  typedef struct packed {
    logic                cell_tested;
    logic                detected;
    logic                dropped;
    logic [BIN_W-1:0]    cut_bin;
    logic [MAXDET_W-1:0] detection_count;
    logic                frame_done;
  } det_t;

endpackage

/* rtl/core/cacfar_if.sv */
// Valid/ready channel interfaces for spectrum bins in and detection results out.
interface cacfar_bin_if #(
  parameter int MAG_BITS = 24
);
  logic                valid;
  logic                ready;
  logic [MAG_BITS-1:0] magnitude;
  logic                frame_end;

  modport source (output valid, magnitude, frame_end, input ready);
  modport sink   (input valid, magnitude, frame_end, output ready);
endinterface

interface cacfar_det_if
  import cacfar_pkg::*;
;
  logic valid;
  logic ready;
  det_t det;

  modport source (output valid, det, input ready);
  modport sink   (input valid, det, output ready);
endinterface

/* rtl/core/cell_averaging_cfar_detector.sv */
// An accepted bin beat travels the window, sum, product and result
// registers. Throughput: one bin per cycle unless det_o.ready stalls; the
// multiply and threshold compare are split over the sum, product and result
// registers. Each bin gives exactly one result beat, in order.
// Reset clears the delay line, training sums, frame position, detection
// count and pipeline valids, and loads the gain and limit defaults.
module cell_averaging_cfar_detector
  import cacfar_pkg::*;
#(
  parameter int TRAIN_CELLS = 8,
  parameter int GUARD_CELLS = 2,
  parameter int MAX_BINS    = 1024,
  parameter int MAG_BITS    = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cacfar_bin_if.sink            bin_i,
  cacfar_det_if.source          det_o
);

  localparam int SUM_W = MAG_BITS + $clog2(TRAIN_CELLS + 1);
  localparam int TOT_W = SUM_W + 1;
  localparam int LHS_K = 2 * TRAIN_CELLS * 256;
  localparam int LHS_W = MAG_BITS + $clog2(LHS_K + 1);
  localparam int RHS_W = TOT_W + GAIN_W;
  localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  // Configuration registers
  logic [GAIN_W-1:0]   gain_q;
  logic [MAXDET_W-1:0] maxdet_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RST;
      maxdet_q <= MAXDET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_Q8: gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_MAX_DET: maxdet_q <= cfg_data_i[MAXDET_W-1:0];
      endcase
    end
  end

  // Window stage
  logic                w_valid;
  win_ctrl_t           w_ctrl;
  logic [MAG_BITS-1:0] w_cut;
  logic [SUM_W-1:0]    w_lead;
  logic [SUM_W-1:0]    w_lag;
  logic                s2_ready;

  cacfar_window #(
    .TRAIN_CELLS(TRAIN_CELLS),
    .GUARD_CELLS(GUARD_CELLS),
    .MAX_BINS   (MAX_BINS),
    .MAG_BITS   (MAG_BITS)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (bin_i.valid),
    .in_ready_o (bin_i.ready),
    .magnitude_i(bin_i.magnitude),
    .frame_end_i(bin_i.frame_end),
    .out_valid_o(w_valid),
    .out_ready_i(s2_ready),
    .ctrl_o     (w_ctrl),
    .cut_o      (w_cut),
    .lead_o     (w_lead),
    .lag_o      (w_lag)
  );

  // Pipeline registers
  logic                s2_valid_q, s3_valid_q, out_valid_q;
  logic                s3_ready, out_ready;
  win_ctrl_t           s2_ctrl_q, s3_ctrl_q;
  logic [MAG_BITS-1:0] s2_cut_q;
  logic [TOT_W-1:0]    s2_sum_q;
  logic [CMP_W-1:0]    s3_lhs_q, s3_rhs_q;
  logic [MAXDET_W-1:0] count_q, count_d;
  det_t                det_q, det_d;
  logic                hit;

  assign out_ready = !out_valid_q || det_o.ready;
  assign s3_ready  = !s3_valid_q || out_ready;
  assign s2_ready  = !s2_valid_q || s3_ready;

  // Threshold test and detection count for the beat leaving the product stage
  always_comb begin
    hit     = s3_ctrl_q.tested && (s3_lhs_q > s3_rhs_q);
    det_d.cell_tested = s3_ctrl_q.tested;
    det_d.detected    = hit && (count_q < maxdet_q);
    det_d.dropped     = hit && !(count_q < maxdet_q);
    det_d.cut_bin     = s3_ctrl_q.cut_bin;
    count_d = det_d.detected ? count_q + MAXDET_W'(1) : count_q;
    det_d.detection_count = count_d;
    det_d.frame_done      = s3_ctrl_q.frame_end;
  end

  // Advance valids and the per-frame count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= w_valid;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s3_valid_q;
        if (s3_valid_q) begin
          count_q <= s3_ctrl_q.frame_end ? '0 : count_d;
        end
      end
    end
  end

  // Sum, product and result payload
  always_ff @(posedge clk_i) begin
    if (s2_ready && w_valid) begin
      s2_ctrl_q <= w_ctrl;
      s2_cut_q  <= w_cut;
      s2_sum_q  <= TOT_W'(w_lead) + TOT_W'(w_lag);
    end
    if (s3_ready && s2_valid_q) begin
      s3_ctrl_q <= s2_ctrl_q;
      s3_lhs_q  <= CMP_W'(s2_cut_q) * CMP_W'(LHS_K);
      s3_rhs_q  <= CMP_W'(s2_sum_q) * CMP_W'(gain_q);
    end
    if (out_ready && s3_valid_q) begin
      det_q <= det_d;
    end
  end

  assign det_o.valid = out_valid_q;
  assign det_o.det   = det_q;

endmodule

/* rtl/core/cacfar_window.sv */
// Delay line, running training sums and frame position of the CFAR detector.
module cacfar_window
  import cacfar_pkg::*;
#(
  parameter int TRAIN_CELLS = 8,
  parameter int GUARD_CELLS = 2,
  parameter int MAX_BINS    = 1024,
  parameter int MAG_BITS    = 24,
  localparam int SUM_W      = MAG_BITS + $clog2(TRAIN_CELLS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [MAG_BITS-1:0] magnitude_i,
  input  logic                frame_end_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output win_ctrl_t           ctrl_o,
  output logic [MAG_BITS-1:0] cut_o,
  output logic [SUM_W-1:0]    lead_o,
  output logic [SUM_W-1:0]    lag_o
);

  localparam int WIN_LEN = 2 * TRAIN_CELLS + 2 * GUARD_CELLS + 1;
  localparam int POS_W   = $clog2(MAX_BINS + 1);
  localparam int CUT_OFS = TRAIN_CELLS + GUARD_CELLS;

  logic [MAG_BITS-1:0] win_q [WIN_LEN];
  logic [SUM_W-1:0]    lead_q, lead_d;
  logic [SUM_W-1:0]    lag_q, lag_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [MAG_BITS-1:0] cut_q;
  win_ctrl_t           ctrl_q, ctrl_d;
  logic                valid_q;
  logic                accept;
  logic                in_range;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = pos_q < POS_W'(MAX_BINS);

  // Slide the training sums: the newest sample enters the leading side and
  // the sample crossing the window edge leaves the lagging side
  assign lead_d = lead_q + SUM_W'(magnitude_i) - SUM_W'(win_q[TRAIN_CELLS-1]);
  assign lag_d  = lag_q + SUM_W'(win_q[WIN_LEN-TRAIN_CELLS-1])
                - SUM_W'(win_q[WIN_LEN-1]);

  // Decide test and position for this beat
  always_comb begin
    ctrl_d.tested    = in_range && (pos_q >= POS_W'(WIN_LEN - 1));
    ctrl_d.frame_end = frame_end_i;
    ctrl_d.cut_bin   = ctrl_d.tested ? BIN_W'(pos_q - POS_W'(CUT_OFS)) : '0;
    if (frame_end_i) begin
      pos_d = '0;
    end else if (in_range) begin
      pos_d = pos_q + POS_W'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  // Advance window and sums on every beat that falls inside the frame limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN_LEN; k++) begin
        win_q[k] <= '0;
      end
      lead_q  <= '0;
      lag_q   <= '0;
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (accept) begin
        pos_q <= pos_d;
        if (in_range) begin
          for (int k = 1; k < WIN_LEN; k++) begin
            win_q[k] <= win_q[k-1];
          end
          win_q[0] <= magnitude_i;
          lead_q   <= lead_d;
          lag_q    <= lag_d;
        end
      end
    end
  end

  // Hold the cell under test and control for the next stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctrl_q <= ctrl_d;
      cut_q  <= win_q[CUT_OFS-1];
    end
  end

  assign out_valid_o = valid_q;
  assign ctrl_o      = ctrl_q;
  assign cut_o       = cut_q;
  assign lead_o      = lead_q;
  assign lag_o       = lag_q;

endmodule

/* rtl/core/cacfar_checker.sv */
// Port-level assertions for the CFAR detector and their bind.
module cacfar_checker
  import cacfar_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic                cell_tested_i,
  input logic                detected_i,
  input logic                dropped_i,
  input logic [MAXDET_W-1:0] detection_count_i
);

`include "cell_averaging_cfar_detector_assert.svh"

  // A stalled result beat stays offered
  `CACFAR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result beat withdrawn")

  // A hit is either recorded or dropped, never both
  `CACFAR_ASSERT_NOW(a_hit_excl, out_valid_i, !(detected_i && dropped_i), "detected and dropped")

  // Only a tested cell can be a hit
  `CACFAR_ASSERT_NOW(a_hit_tested, out_valid_i && (detected_i || dropped_i), cell_tested_i, "hit on untested beat")

  // A recorded hit is counted
  `CACFAR_ASSERT_NOW(a_det_count, out_valid_i && detected_i, detection_count_i != '0, "detection not counted")

endmodule

bind cell_averaging_cfar_detector cacfar_checker u_cacfar_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (det_o.valid),
  .out_ready_i      (det_o.ready),
  .cell_tested_i    (det_o.det.cell_tested),
  .detected_i       (det_o.det.detected),
  .dropped_i        (det_o.det.dropped),
  .detection_count_i(det_o.det.detection_count)
);
